/* rtl/core/ush_pkg.sv */
// shared types and constants for the ultrasonic obstacle hysteresis block
// used by every module under rtl/core; depends on nothing
`default_nettype none

package ush_pkg;

	localparam int unsigned NUM_CHANNELS_DEF = 4;

	// distance in 1/16 cm is (echo_us * DIST_MUL) >> 16
	localparam logic [14:0] DIST_MUL    = 15'd17984;
	localparam logic [13:0] TIMEOUT_D16 = 14'd15984;
	localparam logic [9:0]  TIMEOUT_CM  = 10'd999;

	localparam logic [31:0] ENTER_RESET  = 32'h5F28_2846;
	localparam logic [31:0] EXIT_RESET   = 32'h6E32_3252;
	localparam logic [7:0]  MIN_RESET    = 8'd2;
	localparam logic [15:0] REPEAT_RESET = 16'd2500;

	typedef enum logic [1:0] {
		REG_ENTER     = 2'd0,
		REG_EXIT      = 2'd1,
		REG_MIN_VALID = 2'd2,
		REG_REPEAT    = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_ALERT  = 2'd0,
		EV_CLEAR  = 2'd1,
		EV_REPEAT = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [1:0]  sensor_index;
		logic [14:0] echo_us;
		logic [31:0] now_ms;
	} meas_t;

	typedef struct packed {
		logic [1:0]  alert_channel;
		event_kind_t event_kind;
		logic [9:0]  distance_cm;
	} evt_t;

	typedef struct packed {
		logic [31:0] enter_thresholds;
		logic [31:0] exit_thresholds;
		logic [7:0]  min_valid_cm;
		logic [15:0] repeat_interval_ms;
	} cfg_t;

	// measurement after distance conversion, held in the first stage
	typedef struct packed {
		logic [1:0]  ch;
		logic [13:0] d16;
		logic [9:0]  cm;
		logic [31:0] now_ms;
	} meas_s1_t;

	typedef struct packed {
		logic        fire;
		event_kind_t kind;
	} decision_t;

endpackage

`default_nettype wire

/* rtl/core/ush_cfg_regs.sv */
// apb register file holding thresholds, minimum distance and repeat interval
// depends on ush_pkg for the register index codes and the cfg_t struct
`default_nettype none

module ush_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output ush_pkg::cfg_t     cfg
);

	ush_pkg::cfg_t     cfg_q;
	ush_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = ush_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enter_thresholds   <= ush_pkg::ENTER_RESET;
			cfg_q.exit_thresholds    <= ush_pkg::EXIT_RESET;
			cfg_q.min_valid_cm       <= ush_pkg::MIN_RESET;
			cfg_q.repeat_interval_ms <= ush_pkg::REPEAT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				ush_pkg::REG_ENTER:     cfg_q.enter_thresholds   <= pwdata;
				ush_pkg::REG_EXIT:      cfg_q.exit_thresholds    <= pwdata;
				ush_pkg::REG_MIN_VALID: cfg_q.min_valid_cm       <= pwdata[7:0];
				ush_pkg::REG_REPEAT:    cfg_q.repeat_interval_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ush_pkg::REG_ENTER:     prdata = cfg_q.enter_thresholds;
			ush_pkg::REG_EXIT:      prdata = cfg_q.exit_thresholds;
			ush_pkg::REG_MIN_VALID: prdata = {24'd0, cfg_q.min_valid_cm};
			ush_pkg::REG_REPEAT:    prdata = {16'd0, cfg_q.repeat_interval_ms};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/ush_dist.sv */
// echo width to distance conversion: 1/16 cm for compares, rounded whole cm
// depends on ush_pkg for the scale factor and timeout constants
`default_nettype none

module ush_dist (
	input  wire logic [14:0] echo_us,
	output logic [13:0]      d16,
	output logic [9:0]       cm
);

	logic [29:0] prod;
	logic [14:0] rnd;

	assign prod = {15'd0, echo_us} * {15'd0, ush_pkg::DIST_MUL};
	// round half up, sum stays below 2^14 for any 15-bit echo
	assign rnd  = {1'b0, prod[29:16]} + 15'd8;

	always_comb begin
		if (echo_us == 15'd0) begin
			d16 = ush_pkg::TIMEOUT_D16;
			cm  = ush_pkg::TIMEOUT_CM;
		end else begin
			d16 = prod[29:16];
			cm  = rnd[13:4];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ush_chan.sv */
// per-channel hysteresis state: blocked flags, last alert times, event decision
// depends on ush_pkg for cfg_t, meas_s1_t, decision_t and event codes
`default_nettype none

module ush_chan #(
	parameter int unsigned NUM_CHANNELS = ush_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  ush_pkg::cfg_t            cfg,
	input  wire logic                go,
	input  ush_pkg::meas_s1_t        item,
	output ush_pkg::decision_t       dec
);

	logic        blocked_q   [NUM_CHANNELS];
	logic [31:0] last_time_q [NUM_CHANNELS];

	logic        in_range;
	logic        blk;
	logic [31:0] last;
	logic [4:0]  lane_base;
	logic [13:0] enter16;
	logic [13:0] exit16;
	logic [13:0] min16;
	logic [31:0] elapsed;
	logic        set_blk;
	logic        clr_blk;
	logic        upd_time;

	assign in_range  = 32'(item.ch) < NUM_CHANNELS;
	assign lane_base = {item.ch, 3'b000};
	assign enter16   = {2'b00, cfg.enter_thresholds[lane_base +: 8], 4'b0000};
	assign exit16    = {2'b00, cfg.exit_thresholds[lane_base +: 8], 4'b0000};
	assign min16     = {2'b00, cfg.min_valid_cm, 4'b0000};
	assign elapsed   = item.now_ms - last;

	always_comb begin
		blk  = 1'b0;
		last = 32'd0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (item.ch == 2'(i)) begin
				blk  = blocked_q[i];
				last = last_time_q[i];
			end
		end
	end

	always_comb begin
		dec.fire = 1'b0;
		dec.kind = ush_pkg::EV_ALERT;
		set_blk  = 1'b0;
		clr_blk  = 1'b0;
		upd_time = 1'b0;
		if (in_range) begin
			if (!blk && item.d16 >= min16 && item.d16 < enter16) begin
				dec.fire = 1'b1;
				dec.kind = ush_pkg::EV_ALERT;
				set_blk  = 1'b1;
				upd_time = 1'b1;
			end else if (blk && item.d16 > exit16) begin
				dec.fire = 1'b1;
				dec.kind = ush_pkg::EV_CLEAR;
				clr_blk  = 1'b1;
			end else if (blk && elapsed >= {16'd0, cfg.repeat_interval_ms}) begin
				dec.fire = 1'b1;
				dec.kind = ush_pkg::EV_REPEAT;
				upd_time = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				blocked_q[i]   <= 1'b0;
				last_time_q[i] <= 32'd0;
			end
		end else if (go) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (item.ch == 2'(i)) begin
					if (set_blk) begin
						blocked_q[i] <= 1'b1;
					end else if (clr_blk) begin
						blocked_q[i] <= 1'b0;
					end
					if (upd_time) begin
						last_time_q[i] <= item.now_ms;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ultrasonic_obstacle_hysteresis.sv */
// top level of the ultrasonic obstacle detector with per-channel hysteresis
// depends on ush_pkg, ush_cfg_regs, ush_dist and ush_chan
//
// usage
//   meas channel: valid/ready, one measurement (sensor index, echo width in us,
//   millisecond time) per transaction. the width is converted to distance on
//   the way into the first stage register.
//   evt channel: valid/ready, zero or one event per measurement (new alert,
//   clear, repeated alert) with the rounded distance in cm.
//   apb port: four 32-bit registers at byte offsets 0, 4, 8, 12, pready tied
//   high; write only while no measurement is in flight.
// timing
//   one measurement per cycle while events are taken; a measurement passes
//   the stage register, then the event register. the channel state is read
//   from the stage register and updated as the event register loads, so
//   back-to-back measurements on one channel see each other's effect.
// reset and stall
//   reset clears both stages, all blocked flags and alert times and loads the
//   register defaults. while an event waits, the stage register still takes
//   a measurement; once it is full, meas_ready drops until the event is taken.
`default_nettype none

module ultrasonic_obstacle_hysteresis #(
	parameter int unsigned NUM_CHANNELS = ush_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          meas_valid,
	output logic               meas_ready,
	input  ush_pkg::meas_t     meas_data,
	output logic               evt_valid,
	input  wire logic          evt_ready,
	output ush_pkg::evt_t      evt_data,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	ush_pkg::cfg_t      cfg;
	ush_pkg::meas_s1_t  item_s1;
	ush_pkg::decision_t dec;
	ush_pkg::evt_t      evt_s2;
	logic               valid_s1;
	logic               evt_valid_s2;
	logic               out_free;
	logic [13:0]        d16;
	logic [9:0]         cm;

	ush_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ush_dist u_dist (
		.echo_us (meas_data.echo_us),
		.d16     (d16),
		.cm      (cm)
	);

	assign out_free   = !evt_valid_s2 || evt_ready;
	assign meas_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (meas_ready) begin
			valid_s1 <= meas_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (meas_valid && meas_ready) begin
			item_s1.ch     <= meas_data.sensor_index;
			item_s1.d16    <= d16;
			item_s1.cm     <= cm;
			item_s1.now_ms <= meas_data.now_ms;
		end
	end

	ush_chan #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_chan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.go     (valid_s1 && out_free),
		.item   (item_s1),
		.dec    (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s2 <= 1'b0;
		end else if (out_free) begin
			evt_valid_s2 <= valid_s1 && dec.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && dec.fire) begin
			evt_s2.alert_channel <= item_s1.ch;
			evt_s2.event_kind    <= dec.kind;
			evt_s2.distance_cm   <= item_s1.cm;
		end
	end

	assign evt_valid = evt_valid_s2;
	assign evt_data  = evt_s2;

endmodule

`default_nettype wire

/* rtl/core/ush_checker.sv */
// port-level checks for the ultrasonic obstacle hysteresis top level
// depends on ush_pkg; bound to ultrasonic_obstacle_hysteresis at the end
`default_nettype none

module ush_checker (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      meas_valid,
	input wire logic      meas_ready,
	input ush_pkg::meas_t meas_data,
	input wire logic      evt_valid,
	input wire logic      evt_ready,
	input ush_pkg::evt_t  evt_data
);

	// a stalled event keeps its payload
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt_data))
		else $error("event changed while stalled");

	// alerts need a distance within an 8-bit threshold, so at most 255 cm
	a_alert_dist: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_data.event_kind != ush_pkg::EV_CLEAR
		|-> evt_data.distance_cm <= 10'd255)
		else $error("alert distance out of range");

	// a fresh event must be preceded by a measurement transaction
	a_evt_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(evt_valid) |-> $past(meas_valid && meas_ready, 2))
		else $error("event without a measurement");

	// with no event pending the block always takes a measurement
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!evt_valid |-> meas_ready)
		else $error("measurement refused with empty output");

endmodule

bind ultrasonic_obstacle_hysteresis ush_checker u_ush_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.meas_valid (meas_valid),
	.meas_ready (meas_ready),
	.meas_data  (meas_data),
	.evt_valid  (evt_valid),
	.evt_ready  (evt_ready),
	.evt_data   (evt_data)
);

`default_nettype wire
